// ----- rtl/si_pkg.sv -----
// ----------------------------------------------------------------------------
// si_pkg
// shared constants and control types for the segment intersection pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package si_pkg;

  // width of one coordinate field on the input stream
  localparam int FIELD_W = 16;
  // width of one result coordinate
  localparam int OUT_W   = 24;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;

  // control bits that travel with every pipeline slot
  typedef struct packed {
    logic valid;
    logic par;    // determinant is zero
    logic neg_x;  // sign of the x quotient
    logic neg_y;  // sign of the y quotient
    logic ovf_x;  // x quotient too large, clamp
    logic ovf_y;  // y quotient too large, clamp
  } si_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/segment_intersection.sv -----
// ----------------------------------------------------------------------------
// segment_intersection
// crossing point and hit test of two 2d line segments, fully pipelined
// ----------------------------------------------------------------------------
// Takes one segment pair per beat and returns one result beat per pair, in
// order. Each pair passes in turn through the front stages, the numerator
// stages, the division and the finish stages; the division runs as a chain
// of QB one-bit restoring steps, each its own register stage, where
// QB = max(COORD_BITS + FRAC_BITS + 2, 25) is the number of quotient bits.
// A new pair is taken in every cycle; the whole pipeline only holds while a
// result sits in the output register and the downstream side is not ready.
// Zero determinant gives parallel = 1, hit = 0 and a zero point. Otherwise
// the point is rounded to FRAC_BITS fraction bits (halves away from zero),
// saturated to 24 bits, and hit is 1 when the unsaturated point lies in both
// bounding boxes, edges included.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y,
  // b_end_x, b_end_y (16 bits each)
  input  wire logic [127:0]  s_tdata_i,
  input  wire logic          s_tvalid_i,
  output logic               s_tready_o,
  // cross_x, cross_y (24 bits each)
  output logic [47:0]        m_tdata_o,
  // hit, parallel
  output logic [1:0]         m_tuser_o,
  output logic               m_tvalid_o,
  input  wire logic          m_tready_i
);
  import si_pkg::*;

  localparam int CB  = COORD_BITS;
  localparam int FB  = FRAC_BITS;
  localparam int QB  = (CB + FB + 2 > 25) ? CB + FB + 2 : 25;
  localparam int RW  = 2 * CB + 1;
  localparam int SW  = 10 * CB;

  // global advance: only a held output beat stalls the pipe
  logic en;
  assign en         = !m_tvalid_o || m_tready_i;
  assign s_tready_o = en;

  // front: differences, products, determinant
  si_ctrl_t                 f_ctrl;
  logic signed [2*CB+2:0]   f_det, f_tn;
  logic signed [CB:0]       f_dax, f_day;
  logic [SW-1:0]            f_side;

  si_front #(.CB(CB)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_tvalid_i),
    .coords_i (s_tdata_i),
    .ctrl_o   (f_ctrl),
    .det_o    (f_det),
    .tn_o     (f_tn),
    .dax_o    (f_dax),
    .day_o    (f_day),
    .side_o   (f_side)
  );

  // division chain, index 0 is the numerator stage output
  si_ctrl_t      d_ctrl [QB+1];
  logic [RW-1:0] d_dm   [QB+1];
  logic [RW-1:0] d_rx   [QB+1];
  logic [RW-1:0] d_ry   [QB+1];
  logic [QB-1:0] d_lx   [QB+1];
  logic [QB-1:0] d_ly   [QB+1];
  logic [QB-1:0] d_qx   [QB+1];
  logic [QB-1:0] d_qy   [QB+1];
  logic [SW-1:0] d_side [QB+1];

  si_numer #(.CB(CB), .FB(FB), .QB(QB)) u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctrl_i  (f_ctrl),
    .det_i   (f_det),
    .tn_i    (f_tn),
    .dax_i   (f_dax),
    .day_i   (f_day),
    .side_i  (f_side),
    .ctrl_o  (d_ctrl[0]),
    .dm_o    (d_dm[0]),
    .rem_x_o (d_rx[0]),
    .rem_y_o (d_ry[0]),
    .nlo_x_o (d_lx[0]),
    .nlo_y_o (d_ly[0]),
    .side_o  (d_side[0])
  );

  assign d_qx[0] = '0;
  assign d_qy[0] = '0;

  for (genvar k = 0; k < QB; k++) begin : g_div
    si_div_stage #(.RW(RW), .QB(QB), .SW(SW)) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .ctrl_i  (d_ctrl[k]),
      .dm_i    (d_dm[k]),
      .rem_x_i (d_rx[k]),
      .rem_y_i (d_ry[k]),
      .nlo_x_i (d_lx[k]),
      .nlo_y_i (d_ly[k]),
      .q_x_i   (d_qx[k]),
      .q_y_i   (d_qy[k]),
      .side_i  (d_side[k]),
      .ctrl_o  (d_ctrl[k+1]),
      .dm_o    (d_dm[k+1]),
      .rem_x_o (d_rx[k+1]),
      .rem_y_o (d_ry[k+1]),
      .nlo_x_o (d_lx[k+1]),
      .nlo_y_o (d_ly[k+1]),
      .q_x_o   (d_qx[k+1]),
      .q_y_o   (d_qy[k+1]),
      .side_o  (d_side[k+1])
    );
  end

  // finish: point, box test, saturation, output register
  logic             o_hit, o_par;
  logic [OUT_W-1:0] o_x, o_y;

  si_finish #(.CB(CB), .FB(FB), .QB(QB)) u_finish (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .ctrl_i    (d_ctrl[QB]),
    .q_x_i     (d_qx[QB]),
    .q_y_i     (d_qy[QB]),
    .side_i    (d_side[QB]),
    .valid_o   (m_tvalid_o),
    .hit_o     (o_hit),
    .par_o     (o_par),
    .cross_x_o (o_x),
    .cross_y_o (o_y)
  );

  assign m_tdata_o = {o_y, o_x};
  assign m_tuser_o = {o_par, o_hit};

  // parallel pairs never hit and report a zero point
  a_par_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && m_tuser_o[1] |-> !m_tuser_o[0] && (m_tdata_o == '0))
    else $error("parallel beat with hit or nonzero point");

  // input side only stalls behind a held output beat
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o && !m_tready_i)
    else $error("input stalled without output back-pressure");

  // an empty output register always lets the pipe advance
  a_no_bubble_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid_o |-> s_tready_o)
    else $error("pipe stalled with empty output");

endmodule

`default_nettype wire

// ----- rtl/si_front.sv -----
// ----------------------------------------------------------------------------
// si_front
// direction vectors, cross products, determinant and line parameter numerator
// ----------------------------------------------------------------------------
`default_nettype none

module si_front #(
  parameter int CB = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            en_i,
  input  wire logic                            valid_i,
  input  wire logic [8*si_pkg::FIELD_W-1:0]    coords_i,
  output si_pkg::si_ctrl_t                     ctrl_o,
  output logic signed [2*CB+3-1:0]             det_o,
  output logic signed [2*CB+3-1:0]             tn_o,
  output logic signed [CB:0]                   dax_o,
  output logic signed [CB:0]                   day_o,
  output logic [10*CB-1:0]                     side_o
);
  import si_pkg::*;

  localparam int DW   = CB + 1;
  localparam int PW   = 2 * DW;
  localparam int DETW = PW + 1;
  localparam int EW   = (CB > FIELD_W) ? CB : FIELD_W;

  logic signed [CB-1:0] c [8];
  logic [EW-1:0]        ext [8];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      ext[i] = EW'(coords_i[i*FIELD_W +: FIELD_W]);
      c[i]   = signed'(ext[i][CB-1:0]);
    end
  end

  // stage 1: differences and bounding boxes
  logic                 v1_q;
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, ex1_q, ey1_q;
  logic [10*CB-1:0]     side1_q;
  logic [10*CB-1:0]     side1_d;

  always_comb begin
    side1_d = {
      (c[5] < c[7]) ? c[7] : c[5], (c[5] < c[7]) ? c[5] : c[7],
      (c[4] < c[6]) ? c[6] : c[4], (c[4] < c[6]) ? c[4] : c[6],
      (c[1] < c[3]) ? c[3] : c[1], (c[1] < c[3]) ? c[1] : c[3],
      (c[0] < c[2]) ? c[2] : c[0], (c[0] < c[2]) ? c[0] : c[2],
      c[1], c[0]};
  end

  // stage 2: four products
  logic                 v2_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic [10*CB-1:0]     side2_q;

  // stage 3: determinant and numerator
  logic                   v3_q;
  logic signed [DETW-1:0] det3_q, tn3_q;
  logic signed [DW-1:0]   dax3_q, day3_q;
  logic [10*CB-1:0]       side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax1_q  <= DW'(c[2]) - DW'(c[0]);
      day1_q  <= DW'(c[3]) - DW'(c[1]);
      dbx1_q  <= DW'(c[6]) - DW'(c[4]);
      dby1_q  <= DW'(c[7]) - DW'(c[5]);
      ex1_q   <= DW'(c[4]) - DW'(c[0]);
      ey1_q   <= DW'(c[5]) - DW'(c[1]);
      side1_q <= side1_d;

      p0_q    <= PW'(dax1_q) * PW'(dby1_q);
      p1_q    <= PW'(day1_q) * PW'(dbx1_q);
      p2_q    <= PW'(ex1_q) * PW'(dby1_q);
      p3_q    <= PW'(ey1_q) * PW'(dbx1_q);
      dax2_q  <= dax1_q;
      day2_q  <= day1_q;
      side2_q <= side1_q;

      det3_q  <= DETW'(p0_q) - DETW'(p1_q);
      tn3_q   <= DETW'(p2_q) - DETW'(p3_q);
      dax3_q  <= dax2_q;
      day3_q  <= day2_q;
      side3_q <= side2_q;
    end
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.valid = v3_q;
    ctrl_o.par   = (det3_q == '0);
  end

  assign det_o  = det3_q;
  assign tn_o   = tn3_q;
  assign dax_o  = dax3_q;
  assign day_o  = day3_q;
  assign side_o = side3_q;

endmodule

`default_nettype wire

// ----- rtl/si_numer.sv -----
// ----------------------------------------------------------------------------
// si_numer
// signs, magnitudes, scaled and rounded dividends, overflow detection
// ----------------------------------------------------------------------------
`default_nettype none

module si_numer #(
  parameter int CB = 16,
  parameter int FB = 8,
  parameter int QB = 26
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire si_pkg::si_ctrl_t           ctrl_i,
  input  wire logic signed [2*CB+3-1:0]   det_i,
  input  wire logic signed [2*CB+3-1:0]   tn_i,
  input  wire logic signed [CB:0]         dax_i,
  input  wire logic signed [CB:0]         day_i,
  input  wire logic [10*CB-1:0]           side_i,
  output si_pkg::si_ctrl_t                ctrl_o,
  output logic [2*CB:0]                   dm_o,
  output logic [2*CB:0]                   rem_x_o,
  output logic [2*CB:0]                   rem_y_o,
  output logic [QB-1:0]                   nlo_x_o,
  output logic [QB-1:0]                   nlo_y_o,
  output logic [10*CB-1:0]                side_o
);
  import si_pkg::*;

  localparam int RW = 2 * CB + 1;
  localparam int MW = 3 * CB + 1;
  localparam int NW = MW + FB + 1;
  localparam int HW = NW - QB;
  localparam int CW = (HW > RW) ? HW : RW;

  logic signed [2*CB+3-1:0] det_abs, tn_abs;
  logic signed [CB:0]       dax_abs, day_abs;

  always_comb begin
    det_abs = det_i[2*CB+2] ? -det_i : det_i;
    tn_abs  = tn_i[2*CB+2] ? -tn_i : tn_i;
    dax_abs = dax_i[CB] ? -dax_i : dax_i;
    day_abs = day_i[CB] ? -day_i : day_i;
  end

  // stage 4: magnitude products
  si_ctrl_t      c4_d, c4_q;
  logic [RW-1:0] dm4_q;
  logic [MW-1:0] mx4_q, my4_q;
  logic [10*CB-1:0] side4_q;

  // quotient signs follow the operand signs
  always_comb begin
    c4_d       = ctrl_i;
    c4_d.neg_x = (dax_i[CB] ^ tn_i[2*CB+2]) ^ det_i[2*CB+2];
    c4_d.neg_y = (day_i[CB] ^ tn_i[2*CB+2]) ^ det_i[2*CB+2];
  end

  // stage 5: rounded dividends
  logic [NW-1:0] nx, ny;
  logic [CW-1:0] hx, hy, dmw;
  si_ctrl_t      c5_d, c5_q;
  logic [RW-1:0] dm5_q, rx5_q, ry5_q;
  logic [QB-1:0] lx5_q, ly5_q;
  logic [10*CB-1:0] side5_q;

  always_comb begin
    nx   = (NW'(mx4_q) << FB) + NW'(dm4_q >> 1);
    ny   = (NW'(my4_q) << FB) + NW'(dm4_q >> 1);
    hx   = CW'(nx[NW-1:QB]);
    hy   = CW'(ny[NW-1:QB]);
    dmw  = CW'(dm4_q);
    c5_d = c4_q;
    c5_d.ovf_x = (hx >= dmw);
    c5_d.ovf_y = (hy >= dmw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_q <= '0;
      c5_q <= '0;
    end else if (en_i) begin
      c4_q <= c4_d;
      c5_q <= c5_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm4_q   <= det_abs[RW-1:0];
      mx4_q   <= MW'(dax_abs[CB-1:0]) * MW'(tn_abs[RW-1:0]);
      my4_q   <= MW'(day_abs[CB-1:0]) * MW'(tn_abs[RW-1:0]);
      side4_q <= side_i;

      dm5_q   <= dm4_q;
      rx5_q   <= hx[RW-1:0];
      ry5_q   <= hy[RW-1:0];
      lx5_q   <= nx[QB-1:0];
      ly5_q   <= ny[QB-1:0];
      side5_q <= side4_q;
    end
  end

  assign ctrl_o  = c5_q;
  assign dm_o    = dm5_q;
  assign rem_x_o = rx5_q;
  assign rem_y_o = ry5_q;
  assign nlo_x_o = lx5_q;
  assign nlo_y_o = ly5_q;
  assign side_o  = side5_q;

endmodule

`default_nettype wire

// ----- rtl/si_div_stage.sv -----
// ----------------------------------------------------------------------------
// si_div_stage
// one restoring division step for the x and y lanes, one quotient bit each
// ----------------------------------------------------------------------------
`default_nettype none

module si_div_stage #(
  parameter int RW = 33,
  parameter int QB = 26,
  parameter int SW = 160
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire si_pkg::si_ctrl_t ctrl_i,
  input  wire logic [RW-1:0] dm_i,
  input  wire logic [RW-1:0] rem_x_i,
  input  wire logic [RW-1:0] rem_y_i,
  input  wire logic [QB-1:0] nlo_x_i,
  input  wire logic [QB-1:0] nlo_y_i,
  input  wire logic [QB-1:0] q_x_i,
  input  wire logic [QB-1:0] q_y_i,
  input  wire logic [SW-1:0] side_i,
  output si_pkg::si_ctrl_t   ctrl_o,
  output logic [RW-1:0]      dm_o,
  output logic [RW-1:0]      rem_x_o,
  output logic [RW-1:0]      rem_y_o,
  output logic [QB-1:0]      nlo_x_o,
  output logic [QB-1:0]      nlo_y_o,
  output logic [QB-1:0]      q_x_o,
  output logic [QB-1:0]      q_y_o,
  output logic [SW-1:0]      side_o
);
  import si_pkg::*;

  logic [RW:0] tx, ty, dmx;
  logic        gx, gy;
  logic [RW:0] sx, sy;

  always_comb begin
    tx  = {rem_x_i, nlo_x_i[QB-1]};
    ty  = {rem_y_i, nlo_y_i[QB-1]};
    dmx = {1'b0, dm_i};
    gx  = (tx >= dmx);
    gy  = (ty >= dmx);
    sx  = gx ? tx - dmx : tx;
    sy  = gy ? ty - dmx : ty;
  end

  si_ctrl_t c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0;
    end else if (en_i) begin
      c_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm_o    <= dm_i;
      rem_x_o <= sx[RW-1:0];
      rem_y_o <= sy[RW-1:0];
      nlo_x_o <= nlo_x_i << 1;
      nlo_y_o <= nlo_y_i << 1;
      q_x_o   <= {q_x_i[QB-2:0], gx};
      q_y_o   <= {q_y_i[QB-2:0], gy};
      side_o  <= side_i;
    end
  end

  assign ctrl_o = c_q;

endmodule

`default_nettype wire

// ----- rtl/si_finish.sv -----
// ----------------------------------------------------------------------------
// si_finish
// point assembly, bounding box test, saturation and output register
// ----------------------------------------------------------------------------
`default_nettype none

module si_finish #(
  parameter int CB = 16,
  parameter int FB = 8,
  parameter int QB = 26
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire si_pkg::si_ctrl_t            ctrl_i,
  input  wire logic [QB-1:0]               q_x_i,
  input  wire logic [QB-1:0]               q_y_i,
  input  wire logic [10*CB-1:0]            side_i,
  output logic                             valid_o,
  output logic                             hit_o,
  output logic                             par_o,
  output logic [si_pkg::OUT_W-1:0]         cross_x_o,
  output logic [si_pkg::OUT_W-1:0]         cross_y_o
);
  import si_pkg::*;

  localparam int PXW = QB + 2;

  logic [QB:0]           qmx, qmy;
  logic signed [PXW-1:0] px_d, py_d;

  always_comb begin
    qmx  = ctrl_i.ovf_x ? {1'b1, {QB{1'b0}}} : {1'b0, q_x_i};
    qmy  = ctrl_i.ovf_y ? {1'b1, {QB{1'b0}}} : {1'b0, q_y_i};
    px_d = (PXW'(signed'(side_i[0 +: CB])) <<< FB)
         + (ctrl_i.neg_x ? -signed'(PXW'(qmx)) : signed'(PXW'(qmx)));
    py_d = (PXW'(signed'(side_i[CB +: CB])) <<< FB)
         + (ctrl_i.neg_y ? -signed'(PXW'(qmy)) : signed'(PXW'(qmy)));
  end

  // stage f1
  si_ctrl_t              c1_q;
  logic signed [PXW-1:0] px_q, py_q;
  logic [8*CB-1:0]       box_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= px_d;
      py_q  <= py_d;
      box_q <= side_i[10*CB-1:2*CB];
    end
  end

  function automatic logic signed [PXW-1:0] scale_bound(input logic [CB-1:0] b);
    scale_bound = PXW'(signed'(b)) <<< FB;
  endfunction

  function automatic logic [OUT_W-1:0] sat(input logic signed [PXW-1:0] v);
    if (v > PXW'(OUT_MAX)) begin
      sat = OUT_W'(OUT_MAX);
    end else if (v < PXW'(OUT_MIN)) begin
      sat = OUT_W'(OUT_MIN);
    end else begin
      sat = v[OUT_W-1:0];
    end
  endfunction

  logic in_ax, in_ay, in_bx, in_by, hit_d;

  always_comb begin
    in_ax = (px_q >= scale_bound(box_q[0*CB +: CB])) && (px_q <= scale_bound(box_q[1*CB +: CB]));
    in_ay = (py_q >= scale_bound(box_q[2*CB +: CB])) && (py_q <= scale_bound(box_q[3*CB +: CB]));
    in_bx = (px_q >= scale_bound(box_q[4*CB +: CB])) && (px_q <= scale_bound(box_q[5*CB +: CB]));
    in_by = (py_q >= scale_bound(box_q[6*CB +: CB])) && (py_q <= scale_bound(box_q[7*CB +: CB]));
    hit_d = !c1_q.par && in_ax && in_ay && in_bx && in_by;
  end

  // stage f2 is the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q    <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      c1_q    <= ctrl_i;
      valid_o <= c1_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_o     <= hit_d;
      par_o     <= c1_q.par;
      cross_x_o <= c1_q.par ? '0 : sat(px_q);
      cross_y_o <= c1_q.par ? '0 : sat(py_q);
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_segment_intersection.sv -----
// ----------------------------------------------------------------------------
// tb_segment_intersection
// self-checking bench for the segment intersection pipeline
// ----------------------------------------------------------------------------
// Segment pairs are queued by an initial block and streamed in by a clocked
// driver. A predictor in the bench computes the expected result of each
// accepted beat with exact wide integer math. A clocked monitor compares
// every output beat with the oldest expectation. The run walks through four
// phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection;
  import si_pkg::*;

  localparam int FRAC = 8;

  typedef struct {
    logic                    hit;
    logic                    parallel;
    logic signed [OUT_W-1:0] cross_x;
    logic signed [OUT_W-1:0] cross_y;
  } crossing_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic [127:0] s_tdata_i = '0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [47:0]  m_tdata_o;
  logic [1:0]   m_tuser_o;
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;

  logic [127:0] pair_queue[$];
  crossing_t    crossing_queue[$];
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;
  bit           beat_taken = 1'b0;
  int           error_count = 0;

  segment_intersection dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_tdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i)
  );

  always #5 clk_i = ~clk_i;

  // append one pair to the pending queue
  task automatic add_pair(input logic [127:0] pair);
    pair_queue.insert(pair_queue.size(), pair);
  endtask

  function automatic logic [63:0] magnitude(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // a0 + d * tn / det at FRAC fraction bits, halves rounded away from zero
  function automatic longint fixed_coord(longint a0, longint d, longint tn, longint det);
    logic         neg;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quot;
    longint       qm;
    neg  = ((d < 0) != (tn < 0)) != (det < 0);
    den  = 128'(magnitude(det));
    num  = 128'(magnitude(d)) * 128'(magnitude(tn));
    num  = (num << FRAC) + (den >> 1);
    quot = num / den;
    // clamp huge quotients far outside any box
    qm = (quot > (128'd1 << 62)) ? (longint'(1) <<< 62) : longint'(quot[63:0]);
    return a0 * 256 + (neg ? -qm : qm);
  endfunction

  function automatic bit in_box(longint p, longint e0, longint e1);
    longint lo;
    longint hi;
    lo = (e0 < e1 ? e0 : e1) * 256;
    hi = (e0 < e1 ? e1 : e0) * 256;
    return p >= lo && p <= hi;
  endfunction

  function automatic logic [OUT_W-1:0] saturate(longint v);
    if (v > OUT_MAX) return OUT_W'(OUT_MAX);
    if (v < OUT_MIN) return OUT_W'(OUT_MIN);
    return v[OUT_W-1:0];
  endfunction

  function automatic crossing_t predict_crossing(logic [127:0] pair);
    crossing_t r;
    longint    ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint    dax, day, dbx, dby, det, tn, px, py;
    ax0 = $signed(pair[15:0]);    ay0 = $signed(pair[31:16]);
    ax1 = $signed(pair[47:32]);   ay1 = $signed(pair[63:48]);
    bx0 = $signed(pair[79:64]);   by0 = $signed(pair[95:80]);
    bx1 = $signed(pair[111:96]);  by1 = $signed(pair[127:112]);
    dax = ax1 - ax0;  day = ay1 - ay0;
    dbx = bx1 - bx0;  dby = by1 - by0;
    det = dax * dby - day * dbx;
    if (det == 0) begin
      r.hit = 1'b0;  r.parallel = 1'b1;  r.cross_x = '0;  r.cross_y = '0;
      return r;
    end
    tn = (bx0 - ax0) * dby - (by0 - ay0) * dbx;
    px = fixed_coord(ax0, dax, tn, det);
    py = fixed_coord(ay0, day, tn, det);
    // box test on the unsaturated point
    r.hit = in_box(px, ax0, ax1) && in_box(py, ay0, ay1) &&
            in_box(px, bx0, bx1) && in_box(py, by0, by1);
    r.parallel = 1'b0;
    r.cross_x  = saturate(px);
    r.cross_y  = saturate(py);
    return r;
  endfunction

  function automatic logic [127:0] pack_pair(int ax0, int ay0, int ax1, int ay1,
                                             int bx0, int by0, int bx1, int by1);
    return {16'(by1), 16'(bx1), 16'(by0), 16'(bx0),
            16'(ay1), 16'(ax1), 16'(ay0), 16'(ax0)};
  endfunction

  // mostly small coordinates so that hits are common, with some full range
  function automatic int random_coord(int mode);
    case (mode)
      0: begin
        return $urandom_range(64) - 32;
      end
      1: begin
        return $urandom_range(2000) - 1000;
      end
      2: begin
        return ($urandom_range(1)) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
      end
      default: begin
        return int'($signed(16'($urandom)));
      end
    endcase
  endfunction

  // driver: inputs change on the falling edge, a held beat stays put
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_tvalid_i || beat_taken) begin
        if (pair_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          s_tvalid_i <= 1'b1;
          s_tdata_i  <= pair_queue[0];
        end else begin
          s_tvalid_i <= 1'b0;
        end
      end
      m_tready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
    beat_taken = 1'b0;
  end

  // input acceptance and output checking on the rising edge
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && s_tvalid_i && s_tready_o) begin
      crossing_queue.insert(crossing_queue.size(),
                            predict_crossing(pair_queue.pop_front()));
      beat_taken = 1'b1;
    end
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (crossing_queue.size() == 0) begin
        $error("output beat with no expectation pending");
        error_count++;
      end else begin
        want = crossing_queue.pop_front();
        if (m_tuser_o[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_tuser_o[0]);
          error_count++;
        end
        if (m_tuser_o[1] !== want.parallel) begin
          $error("parallel: expected %0d, got %0d", want.parallel, m_tuser_o[1]);
          error_count++;
        end
        if (m_tdata_o[23:0] !== want.cross_x) begin
          $error("cross_x: expected %0d, got %0d", want.cross_x,
                 $signed(m_tdata_o[23:0]));
          error_count++;
        end
        if (m_tdata_o[47:24] !== want.cross_y) begin
          $error("cross_y: expected %0d, got %0d", want.cross_y,
                 $signed(m_tdata_o[47:24]));
          error_count++;
        end
      end
    end
  end

  initial begin
    int idle_by_phase[4];
    int stall_by_phase[4];
    int mode;
    idle_by_phase  = '{0, 76, 0, 26};
    stall_by_phase = '{0, 0, 76, 26};
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pairs
    add_pair(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));        // plain cross
    add_pair(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));          // parallel
    add_pair(pack_pair(0, 0, 10, 10, 2, 2, 8, 8));          // collinear
    add_pair(pack_pair(3, 3, 3, 3, 0, 0, 5, 5));            // zero length
    add_pair(pack_pair(5, 0, 5, 9, 5, 2, 5, 7));            // both vertical
    add_pair(pack_pair(5, -4, 5, 9, 0, 0, 10, 2));          // one vertical
    add_pair(pack_pair(0, 0, 10, 0, 10, 0, 10, 7));         // touch at endpoint
    add_pair(pack_pair(0, 0, 10, 0, 11, -3, 11, 5));        // just outside
    add_pair(pack_pair(0, 0, 3, 1, 0, 1, 1, 0));            // fraction
    add_pair(pack_pair(0, 0, 1, 3, 0, 1, 2, 0));            // rounding
    add_pair(pack_pair(0, 0, -1, 512, 1, 0, 1, 1));         // unit determinant, miss
    add_pair(pack_pair(-32768, -32768, 32767, 32767,
                       -32768, 32767, 32767, -32768));      // extremes
    add_pair(pack_pair(32767, 32767, 32767, -32768,
                       -32768, 32767, 32767, 32767));       // corner hit
    add_pair(pack_pair(-32768, 0, -32767, 1, 32767, 0, 32767, 1)); // saturate
    add_pair(pack_pair(0, 0, 1, 32767, 1, 0, 0, 32767));    // near parallel
    add_pair(pack_pair(-32768, -32768, 32767, -32767,
                       -32768, -32767, 32767, -32768));     // shallow
    add_pair(pack_pair(32767, 0, -32768, 1, 32767, 1, -32768, 0));
    add_pair(pack_pair(-1, -1, -1, -1, -1, -1, -1, -1));

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct    = idle_by_phase[phase];
      receiver_stall_pct = stall_by_phase[phase];
      for (int i = 0; i < 188; i++) begin
        mode = $urandom_range(9);
        mode = (mode < 5) ? 0 : (mode < 7) ? 1 : (mode < 8) ? 2 : 3;
        add_pair(pack_pair(random_coord(mode), random_coord(mode),
                           random_coord(mode), random_coord(mode),
                           random_coord(mode), random_coord(mode),
                           random_coord(mode), random_coord(mode)));
      end
      while (pair_queue.size() > 0 || crossing_queue.size() > 0 || s_tvalid_i)
        @(posedge clk_i);
    end
    sender_idle_pct = 100;
    repeat (60) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/si_pkg.sv
rtl/si_front.sv
rtl/si_numer.sv
rtl/si_div_stage.sv
rtl/si_finish.sv
rtl/segment_intersection.sv
sim/tb_segment_intersection.sv
